FILE: design/rvex_pkg.sv
// Shared types and constants for the RV32I execute stage pipeline.
// Used by every module in this folder; depends on nothing.
package rvex_pkg;

   // Operation kinds as they arrive on req_op
   localparam logic [5:0] OP_LUI   = 6'd0;
   localparam logic [5:0] OP_AUIPC = 6'd1;
   localparam logic [5:0] OP_JAL   = 6'd2;
   localparam logic [5:0] OP_JALR  = 6'd3;
   localparam logic [5:0] OP_BEQ   = 6'd4;
   localparam logic [5:0] OP_BNE   = 6'd5;
   localparam logic [5:0] OP_BLT   = 6'd6;
   localparam logic [5:0] OP_BGE   = 6'd7;
   localparam logic [5:0] OP_BLTU  = 6'd8;
   localparam logic [5:0] OP_BGEU  = 6'd9;
   localparam logic [5:0] OP_LB    = 6'd10;
   localparam logic [5:0] OP_LH    = 6'd11;
   localparam logic [5:0] OP_LW    = 6'd12;
   localparam logic [5:0] OP_LBU   = 6'd13;
   localparam logic [5:0] OP_LHU   = 6'd14;
   localparam logic [5:0] OP_SB    = 6'd15;
   localparam logic [5:0] OP_SH    = 6'd16;
   localparam logic [5:0] OP_SW    = 6'd17;
   localparam logic [5:0] OP_ADDI  = 6'd18;
   localparam logic [5:0] OP_SLTI  = 6'd19;
   localparam logic [5:0] OP_SLTIU = 6'd20;
   localparam logic [5:0] OP_XORI  = 6'd21;
   localparam logic [5:0] OP_ORI   = 6'd22;
   localparam logic [5:0] OP_ANDI  = 6'd23;
   localparam logic [5:0] OP_SLLI  = 6'd24;
   localparam logic [5:0] OP_SRLI  = 6'd25;
   localparam logic [5:0] OP_SRAI  = 6'd26;
   localparam logic [5:0] OP_ADD   = 6'd27;
   localparam logic [5:0] OP_SUB   = 6'd28;
   localparam logic [5:0] OP_SLL   = 6'd29;
   localparam logic [5:0] OP_SLT   = 6'd30;
   localparam logic [5:0] OP_SLTU  = 6'd31;
   localparam logic [5:0] OP_XOR   = 6'd32;
   localparam logic [5:0] OP_SRL   = 6'd33;
   localparam logic [5:0] OP_SRA   = 6'd34;
   localparam logic [5:0] OP_OR    = 6'd35;
   localparam logic [5:0] OP_AND   = 6'd36;

   // Memory access sizes in bytes
   localparam logic [2:0] LEN_NONE = 3'd0;
   localparam logic [2:0] LEN_BYTE = 3'd1;
   localparam logic [2:0] LEN_HALF = 3'd2;
   localparam logic [2:0] LEN_WORD = 3'd4;

   // Upper immediate shift and link offset
   localparam int          UPPER_SHIFT = 12;
   localparam logic [31:0] LINK_OFFSET = 32'd4;
   localparam logic [31:0] BYTE_MASK   = 32'h0000_00FF;
   localparam logic [31:0] HALF_MASK   = 32'h0000_FFFF;

   // Result source / ALU function
   typedef enum logic [3:0] {
      FN_NONE, FN_LUI, FN_AUIPC, FN_LINK, FN_BRANCH, FN_MEM,
      FN_ADD, FN_SUB, FN_SLT, FN_SLTU, FN_XOR, FN_OR, FN_AND,
      FN_SLL, FN_SRL, FN_SRA
   } fn_type;

   // Control transfer kind
   typedef enum logic [3:0] {
      BR_NONE, BR_EQ, BR_NE, BR_LT, BR_GE, BR_LTU, BR_GEU, BR_JAL, BR_JALR
   } br_type;

   // Store data masking
   typedef enum logic [1:0] {
      SM_PASS, SM_BYTE, SM_HALF
   } smask_type;

   typedef struct packed {
      fn_type     fn;
      br_type     br;
      smask_type  smask;
      logic [2:0] len;
      logic       reg_write;
      logic       mem_read;
      logic       mem_write;
      logic       sign_extend;
      logic       bad_op;
   } ctrl_type;

   // Decode stage payload
   typedef struct packed {
      ctrl_type    ctrl;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] imm;
      logic [31:0] pc;
      logic [4:0]  dest;
   } dec_type;

   // ALU stage payload
   typedef struct packed {
      ctrl_type    ctrl;
      logic [31:0] alu_val;
      logic        eq;
      logic        lt_s;
      logic        lt_u;
      logic [31:0] add_ab;
      logic [31:0] pc_plus4;
      logic [31:0] pc_imm;
      logic [31:0] pc_a;
      logic [31:0] addr;
      logic [31:0] sdata;
      logic [31:0] a;
      logic [31:0] pc;
      logic [4:0]  dest;
   } alu_type;

endpackage

FILE: design/rvex_decode.sv
// First pipeline stage: decodes the operation kind into controls and registers the operands.
// Depends on rvex_pkg.
module rvex_decode (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [5:0]        req_op,
   input  logic [31:0]       req_operand_a,
   input  logic [31:0]       req_operand_b,
   input  logic [31:0]       req_immediate,
   input  logic [31:0]       req_pc,
   input  logic [4:0]        req_dest_in,
   output logic              dec_valid,
   output rvex_pkg::dec_type dec_data
);

   logic               valid_ff;
   rvex_pkg::dec_type  data_ff;
   rvex_pkg::dec_type  data_in;
   rvex_pkg::ctrl_type ctrl;

   // Operation decoder
   always_comb begin
      ctrl             = '0;
      ctrl.fn          = rvex_pkg::FN_NONE;
      ctrl.br          = rvex_pkg::BR_NONE;
      ctrl.smask       = rvex_pkg::SM_PASS;
      ctrl.len         = rvex_pkg::LEN_NONE;
      unique case (req_op)
         rvex_pkg::OP_LUI: begin
            ctrl.fn = rvex_pkg::FN_LUI;   ctrl.reg_write = 1'b1;
         end
         rvex_pkg::OP_AUIPC: begin
            ctrl.fn = rvex_pkg::FN_AUIPC; ctrl.reg_write = 1'b1;
         end
         rvex_pkg::OP_JAL: begin
            ctrl.fn = rvex_pkg::FN_LINK;  ctrl.br = rvex_pkg::BR_JAL;
            ctrl.reg_write = 1'b1;
         end
         rvex_pkg::OP_JALR: begin
            ctrl.fn = rvex_pkg::FN_LINK;  ctrl.br = rvex_pkg::BR_JALR;
            ctrl.reg_write = 1'b1;
         end
         rvex_pkg::OP_BEQ:  begin ctrl.fn = rvex_pkg::FN_BRANCH; ctrl.br = rvex_pkg::BR_EQ;  end
         rvex_pkg::OP_BNE:  begin ctrl.fn = rvex_pkg::FN_BRANCH; ctrl.br = rvex_pkg::BR_NE;  end
         rvex_pkg::OP_BLT:  begin ctrl.fn = rvex_pkg::FN_BRANCH; ctrl.br = rvex_pkg::BR_LT;  end
         rvex_pkg::OP_BGE:  begin ctrl.fn = rvex_pkg::FN_BRANCH; ctrl.br = rvex_pkg::BR_GE;  end
         rvex_pkg::OP_BLTU: begin ctrl.fn = rvex_pkg::FN_BRANCH; ctrl.br = rvex_pkg::BR_LTU; end
         rvex_pkg::OP_BGEU: begin ctrl.fn = rvex_pkg::FN_BRANCH; ctrl.br = rvex_pkg::BR_GEU; end
         rvex_pkg::OP_LB, rvex_pkg::OP_LH, rvex_pkg::OP_LW,
         rvex_pkg::OP_LBU, rvex_pkg::OP_LHU: begin
            ctrl.fn        = rvex_pkg::FN_MEM;
            ctrl.mem_read  = 1'b1;
            ctrl.reg_write = 1'b1;
            ctrl.sign_extend = (req_op == rvex_pkg::OP_LB) || (req_op == rvex_pkg::OP_LH)
                               || (req_op == rvex_pkg::OP_LW);
            if ((req_op == rvex_pkg::OP_LB) || (req_op == rvex_pkg::OP_LBU)) begin
               ctrl.len = rvex_pkg::LEN_BYTE;
            end else if ((req_op == rvex_pkg::OP_LH) || (req_op == rvex_pkg::OP_LHU)) begin
               ctrl.len = rvex_pkg::LEN_HALF;
            end else begin
               ctrl.len = rvex_pkg::LEN_WORD;
            end
         end
         rvex_pkg::OP_SB: begin
            ctrl.fn = rvex_pkg::FN_MEM; ctrl.mem_write = 1'b1;
            ctrl.len = rvex_pkg::LEN_BYTE; ctrl.smask = rvex_pkg::SM_BYTE;
         end
         rvex_pkg::OP_SH: begin
            ctrl.fn = rvex_pkg::FN_MEM; ctrl.mem_write = 1'b1;
            ctrl.len = rvex_pkg::LEN_HALF; ctrl.smask = rvex_pkg::SM_HALF;
         end
         rvex_pkg::OP_SW: begin
            ctrl.fn = rvex_pkg::FN_MEM; ctrl.mem_write = 1'b1;
            ctrl.len = rvex_pkg::LEN_WORD;
         end
         rvex_pkg::OP_ADDI, rvex_pkg::OP_ADD: begin
            ctrl.fn = rvex_pkg::FN_ADD;  ctrl.reg_write = 1'b1;
         end
         rvex_pkg::OP_SUB: begin
            ctrl.fn = rvex_pkg::FN_SUB;  ctrl.reg_write = 1'b1;
         end
         rvex_pkg::OP_SLTI, rvex_pkg::OP_SLT: begin
            ctrl.fn = rvex_pkg::FN_SLT;  ctrl.reg_write = 1'b1;
         end
         rvex_pkg::OP_SLTIU, rvex_pkg::OP_SLTU: begin
            ctrl.fn = rvex_pkg::FN_SLTU; ctrl.reg_write = 1'b1;
         end
         rvex_pkg::OP_XORI, rvex_pkg::OP_XOR: begin
            ctrl.fn = rvex_pkg::FN_XOR;  ctrl.reg_write = 1'b1;
         end
         rvex_pkg::OP_ORI, rvex_pkg::OP_OR: begin
            ctrl.fn = rvex_pkg::FN_OR;   ctrl.reg_write = 1'b1;
         end
         rvex_pkg::OP_ANDI, rvex_pkg::OP_AND: begin
            ctrl.fn = rvex_pkg::FN_AND;  ctrl.reg_write = 1'b1;
         end
         rvex_pkg::OP_SLLI, rvex_pkg::OP_SLL: begin
            ctrl.fn = rvex_pkg::FN_SLL;  ctrl.reg_write = 1'b1;
         end
         rvex_pkg::OP_SRLI, rvex_pkg::OP_SRL: begin
            ctrl.fn = rvex_pkg::FN_SRL;  ctrl.reg_write = 1'b1;
         end
         rvex_pkg::OP_SRAI, rvex_pkg::OP_SRA: begin
            ctrl.fn = rvex_pkg::FN_SRA;  ctrl.reg_write = 1'b1;
         end
         default: begin
            ctrl.bad_op = 1'b1;
         end
      endcase
   end

   // Stage payload
   always_comb begin
      data_in      = '0;
      data_in.ctrl = ctrl;
      data_in.a    = req_operand_a;
      data_in.b    = req_operand_b;
      data_in.imm  = req_immediate;
      data_in.pc   = req_pc;
      data_in.dest = req_dest_in;
   end

   // Valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= start;
      end
   end

   // Payload register, no reset
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign dec_valid = valid_ff;
   assign dec_data  = data_ff;

endmodule

FILE: design/rvex_alu.sv
// Second pipeline stage: adders, comparators, shifter and logic unit.
// Depends on rvex_pkg.
module rvex_alu (
   input  logic              clock,
   input  logic              reset,
   input  logic              dec_valid,
   input  rvex_pkg::dec_type dec_data,
   output logic              alu_valid,
   output rvex_pkg::alu_type alu_data
);

   logic              valid_ff;
   rvex_pkg::alu_type data_ff;
   rvex_pkg::alu_type data_in;
   logic [32:0]       diff;
   logic [4:0]        sh;
   logic [31:0]       upper;
   logic              lt_s;

   assign diff  = {1'b0, dec_data.a} - {1'b0, dec_data.b};
   assign sh    = dec_data.b[4:0];
   assign upper = dec_data.imm << rvex_pkg::UPPER_SHIFT;
   // Signed compare from the unsigned borrow and the sign bits
   assign lt_s  = (dec_data.a[31] ^ dec_data.b[31]) ? dec_data.a[31] : diff[32];

   always_comb begin
      data_in          = '0;
      data_in.ctrl     = dec_data.ctrl;
      data_in.eq       = (dec_data.a == dec_data.b);
      data_in.lt_s     = lt_s;
      data_in.lt_u     = diff[32];
      data_in.add_ab   = dec_data.a + dec_data.b;
      data_in.pc_plus4 = dec_data.pc + rvex_pkg::LINK_OFFSET;
      data_in.pc_a     = dec_data.pc + dec_data.a;
      data_in.addr     = dec_data.a + dec_data.imm;
      data_in.a        = dec_data.a;
      data_in.pc       = dec_data.pc;
      data_in.dest     = dec_data.dest;

      // AUIPC and branches share the pc adder
      if (dec_data.ctrl.fn == rvex_pkg::FN_AUIPC) begin
         data_in.pc_imm = dec_data.pc + upper;
      end else begin
         data_in.pc_imm = dec_data.pc + dec_data.imm;
      end

      // Store data masked to access size
      case (dec_data.ctrl.smask)
         rvex_pkg::SM_BYTE: data_in.sdata = dec_data.b & rvex_pkg::BYTE_MASK;
         rvex_pkg::SM_HALF: data_in.sdata = dec_data.b & rvex_pkg::HALF_MASK;
         default:           data_in.sdata = dec_data.b;
      endcase

      // ALU result for register and immediate forms, and LUI
      case (dec_data.ctrl.fn)
         rvex_pkg::FN_LUI:  data_in.alu_val = upper;
         rvex_pkg::FN_ADD:  data_in.alu_val = dec_data.a + dec_data.b;
         rvex_pkg::FN_SUB:  data_in.alu_val = diff[31:0];
         rvex_pkg::FN_SLT:  data_in.alu_val = {31'd0, lt_s};
         rvex_pkg::FN_SLTU: data_in.alu_val = {31'd0, diff[32]};
         rvex_pkg::FN_XOR:  data_in.alu_val = dec_data.a ^ dec_data.b;
         rvex_pkg::FN_OR:   data_in.alu_val = dec_data.a | dec_data.b;
         rvex_pkg::FN_AND:  data_in.alu_val = dec_data.a & dec_data.b;
         rvex_pkg::FN_SLL:  data_in.alu_val = dec_data.a << sh;
         rvex_pkg::FN_SRL:  data_in.alu_val = dec_data.a >> sh;
         rvex_pkg::FN_SRA:  data_in.alu_val = 32'($signed(dec_data.a) >>> sh);
         default:           data_in.alu_val = '0;
      endcase
   end

   // Valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= dec_valid;
      end
   end

   // Payload register, no reset
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign alu_valid = valid_ff;
   assign alu_data  = data_ff;

endmodule

FILE: design/rvex_resolve.sv
// Third pipeline stage: branch resolution, result select and output registers.
// Depends on rvex_pkg.
module rvex_resolve (
   input  logic              clock,
   input  logic              reset,
   input  logic              alu_valid,
   input  rvex_pkg::alu_type alu_data,
   output logic              rsp_valid,
   output logic [31:0]       rsp_result,
   output logic [31:0]       rsp_store_data,
   output logic [31:0]       rsp_base_out,
   output logic [4:0]        rsp_dest_out,
   output logic [2:0]        rsp_access_bytes,
   output logic              rsp_reg_write,
   output logic              rsp_mem_read,
   output logic              rsp_mem_write,
   output logic              rsp_sign_extend,
   output logic              rsp_taken,
   output logic [31:0]       rsp_next_pc,
   output logic              rsp_bad_op
);

   logic        valid_ff;
   logic [31:0] result_ff, result_in;
   logic [31:0] sdata_ff;
   logic [31:0] base_ff;
   logic [4:0]  dest_ff;
   logic [2:0]  len_ff;
   logic        reg_write_ff, mem_read_ff, mem_write_ff, sign_extend_ff, bad_op_ff;
   logic        taken_ff, taken_in;
   logic [31:0] next_pc_ff, next_pc_in;
   logic        cond;

   // Branch condition
   always_comb begin
      case (alu_data.ctrl.br)
         rvex_pkg::BR_EQ:  cond = alu_data.eq;
         rvex_pkg::BR_NE:  cond = !alu_data.eq;
         rvex_pkg::BR_LT:  cond = alu_data.lt_s;
         rvex_pkg::BR_GE:  cond = !alu_data.lt_s;
         rvex_pkg::BR_LTU: cond = alu_data.lt_u;
         rvex_pkg::BR_GEU: cond = !alu_data.lt_u;
         default:          cond = 1'b0;
      endcase
   end

   // Taken flag and next pc
   always_comb begin
      case (alu_data.ctrl.br)
         rvex_pkg::BR_JAL: begin
            taken_in   = 1'b1;
            next_pc_in = alu_data.pc_a;
         end
         rvex_pkg::BR_JALR: begin
            taken_in   = 1'b1;
            next_pc_in = {alu_data.add_ab[31:1], 1'b0};
         end
         default: begin
            taken_in   = cond;
            next_pc_in = cond ? alu_data.pc_imm : alu_data.pc;
         end
      endcase
   end

   // Result select
   always_comb begin
      case (alu_data.ctrl.fn)
         rvex_pkg::FN_NONE, rvex_pkg::FN_BRANCH: result_in = '0;
         rvex_pkg::FN_AUIPC:                     result_in = alu_data.pc_imm;
         rvex_pkg::FN_LINK:                      result_in = alu_data.pc_plus4;
         rvex_pkg::FN_MEM:                       result_in = alu_data.addr;
         default:                                result_in = alu_data.alu_val;
      endcase
   end

   // Result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= alu_valid;
      end
   end

   // Output payload registers, no reset
   always_ff @(posedge clock) begin
      result_ff      <= result_in;
      sdata_ff       <= alu_data.sdata;
      base_ff        <= alu_data.a;
      dest_ff        <= alu_data.dest;
      len_ff         <= alu_data.ctrl.len;
      reg_write_ff   <= alu_data.ctrl.reg_write;
      mem_read_ff    <= alu_data.ctrl.mem_read;
      mem_write_ff   <= alu_data.ctrl.mem_write;
      sign_extend_ff <= alu_data.ctrl.sign_extend;
      bad_op_ff      <= alu_data.ctrl.bad_op;
      taken_ff       <= taken_in;
      next_pc_ff     <= next_pc_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_result       = result_ff;
   assign rsp_store_data   = sdata_ff;
   assign rsp_base_out     = base_ff;
   assign rsp_dest_out     = dest_ff;
   assign rsp_access_bytes = len_ff;
   assign rsp_reg_write    = reg_write_ff;
   assign rsp_mem_read     = mem_read_ff;
   assign rsp_mem_write    = mem_write_ff;
   assign rsp_sign_extend  = sign_extend_ff;
   assign rsp_taken        = taken_ff;
   assign rsp_next_pc      = next_pc_ff;
   assign rsp_bad_op       = bad_op_ff;

endmodule

FILE: design/rv32i_execute_stage_top.sv
// RV32I execute stage: decode, ALU and resolve stages, one register stage each.
// The accepting edge loads the decode stage; rsp_valid strobes once the ALU and resolve registers are loaded in turn.
// Throughput: one transaction per cycle; busy stays low since nothing downstream can stall.
// Reset clears the stage valid bits only; no result is strobed until a new start.
// Depends on rvex_pkg, rvex_decode, rvex_alu and rvex_resolve.
module rv32i_execute_stage_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [5:0]  req_op,
   input  logic [31:0] req_operand_a,
   input  logic [31:0] req_operand_b,
   input  logic [31:0] req_immediate,
   input  logic [31:0] req_pc,
   input  logic [4:0]  req_dest_in,
   output logic        rsp_valid,
   output logic [31:0] rsp_result,
   output logic [31:0] rsp_store_data,
   output logic [31:0] rsp_base_out,
   output logic [4:0]  rsp_dest_out,
   output logic [2:0]  rsp_access_bytes,
   output logic        rsp_reg_write,
   output logic        rsp_mem_read,
   output logic        rsp_mem_write,
   output logic        rsp_sign_extend,
   output logic        rsp_taken,
   output logic [31:0] rsp_next_pc,
   output logic        rsp_bad_op
);

   logic              dec_valid;
   rvex_pkg::dec_type dec_data;
   logic              alu_valid;
   rvex_pkg::alu_type alu_data;

   // Pipeline never backs up
   assign busy = 1'b0;

   rvex_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_op        (req_op),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .req_immediate (req_immediate),
      .req_pc        (req_pc),
      .req_dest_in   (req_dest_in),
      .dec_valid     (dec_valid),
      .dec_data      (dec_data)
   );

   rvex_alu u_alu (
      .clock     (clock),
      .reset     (reset),
      .dec_valid (dec_valid),
      .dec_data  (dec_data),
      .alu_valid (alu_valid),
      .alu_data  (alu_data)
   );

   rvex_resolve u_resolve (
      .clock            (clock),
      .reset            (reset),
      .alu_valid        (alu_valid),
      .alu_data         (alu_data),
      .rsp_valid        (rsp_valid),
      .rsp_result       (rsp_result),
      .rsp_store_data   (rsp_store_data),
      .rsp_base_out     (rsp_base_out),
      .rsp_dest_out     (rsp_dest_out),
      .rsp_access_bytes (rsp_access_bytes),
      .rsp_reg_write    (rsp_reg_write),
      .rsp_mem_read     (rsp_mem_read),
      .rsp_mem_write    (rsp_mem_write),
      .rsp_sign_extend  (rsp_sign_extend),
      .rsp_taken        (rsp_taken),
      .rsp_next_pc      (rsp_next_pc),
      .rsp_bad_op       (rsp_bad_op)
   );

endmodule
